>>> src/tcc_pkg.sv
// Shared constants, codes and control types for the text console block.
package tcc_pkg;

  // Screen geometry.
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ROW_W   = $clog2(ROWS);
  localparam int ADDR_W  = $clog2(CELLS);

  // Field widths on the channels.
  localparam int ACTION_W    = 2;
  localparam int CHAR_W      = 8;
  localparam int READ_ROW_W  = 5;
  localparam int READ_COL_W  = 7;
  localparam int CURSOR_W    = 11;
  localparam int CELL_W      = 16;
  localparam int COLOR_W     = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 4;

  // Item actions.
  typedef enum logic [ACTION_W-1:0] {
    ACT_PUT   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // Character codes with special meaning.
  localparam logic [CHAR_W-1:0] CH_BACKSPACE  = 8'h08;
  localparam logic [CHAR_W-1:0] CH_NEWLINE    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_LAST = 8'h7F;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_FG_COLOR = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BG_COLOR = 2'd1;

  // Reset values.
  localparam logic [COLOR_W-1:0] RESET_FG    = 4'h7;
  localparam logic [COLOR_W-1:0] RESET_BG    = 4'h0;
  localparam logic [CELL_W-1:0]  RESET_CELL  = {RESET_BG, RESET_FG, CH_SPACE};

  // Controller states.
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_FILL,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic exec;
    logic fill_step;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_fill;
    logic is_read;
    logic fill_last;
    logic out_free;
  } dp_status_t;

endpackage

>>> src/tcc_if.sv
// Handshake channel interfaces for input items, result items and configuration writes.
interface tcc_in_if import tcc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [ACTION_W-1:0]   action;
  logic [CHAR_W-1:0]     char_code;
  logic [READ_ROW_W-1:0] read_row;
  logic [READ_COL_W-1:0] read_column;

  modport source (output valid, action, char_code, read_row, read_column, input ready);
  modport sink   (input valid, action, char_code, read_row, read_column, output ready);
endinterface

interface tcc_out_if import tcc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CURSOR_W-1:0] cursor_position;
  logic [CELL_W-1:0]   cell_word;

  modport source (output valid, cursor_position, cell_word, input ready);
  modport sink   (input valid, cursor_position, cell_word, output ready);
endinterface

interface tcc_cfg_if import tcc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/text_console_cursor_scroll_top.sv
// Top level of the text console: controller, datapath and channel wiring.
//
// A text-mode console holding a screen of 25 rows by 80 columns of 16-bit cells
// (attribute in the high byte, character in the low byte) and a cursor. Each
// input item puts a character, clears the screen, reads one cell or does
// nothing, and gives exactly one result item with the cursor position and, for
// a read, the cell. The screen memory has one write port, so a put or newline
// that scrolls then sweeps blanks over the new bottom row and a clear sweeps
// them over all 2000 cells; a read passes through the done state to register
// its cell first. Scrolling moves a row offset instead of copying rows. After
// reset the block runs a clearing pass over all 2000 cells before it takes its
// first item; configuration writes are taken at any time and are meant to be
// made while the block is idle.
module text_console_cursor_scroll_top import tcc_pkg::*; (
  input logic       clk,
  input logic       rst,
  tcc_in_if.sink    in_ch,
  tcc_out_if.source out_ch,
  tcc_cfg_if.sink   cfg
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  assign in_ch.ready = in_ready;
  assign cfg.ready   = 1'b1;

  tcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tcc_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .action          (in_ch.action),
    .char_code       (in_ch.char_code),
    .read_row        (in_ch.read_row),
    .read_column     (in_ch.read_column),
    .cfg_valid       (cfg.valid),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .cursor_position (out_ch.cursor_position),
    .cell_word       (out_ch.cell_word)
  );

endmodule

>>> src/tcc_datapath.sv
// Datapath of the text console: screen memory, cursor, colors, fill sweep and result register.
module tcc_datapath import tcc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  dp_cmd_t                cmd,
  output dp_status_t             status,
  input  logic [ACTION_W-1:0]    action,
  input  logic [CHAR_W-1:0]      char_code,
  input  logic [READ_ROW_W-1:0]  read_row,
  input  logic [READ_COL_W-1:0]  read_column,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [CURSOR_W-1:0]    cursor_position,
  output logic [CELL_W-1:0]      cell_word
);

  localparam int POS_W = (ADDR_W > CURSOR_W) ? ADDR_W : CURSOR_W;
  localparam logic [ADDR_W-1:0]     COLUMNS_A  = ADDR_W'(COLUMNS);
  localparam logic [POS_W-1:0]      COLUMNS_P  = POS_W'(COLUMNS);
  localparam logic [ROW_W:0]        ROWS_S     = (ROW_W + 1)'(ROWS);
  localparam logic [READ_ROW_W:0]   ROWS_R     = (READ_ROW_W + 1)'(ROWS);
  localparam logic [READ_COL_W:0]   COLUMNS_R  = (READ_COL_W + 1)'(COLUMNS);
  localparam logic [COL_W-1:0]      LAST_COL   = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]      LAST_ROW   = ROW_W'(ROWS - 1);
  localparam logic [ADDR_W-1:0]     LAST_CELL  = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0]     ROW_SPAN   = ADDR_W'(COLUMNS - 1);

  // Logical rows sit in memory rotated by top_row, so a scroll needs no copy.
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lrow,
                                               input logic [ROW_W-1:0] top);
    logic [ROW_W:0] sum;
    sum = {1'b0, lrow} + {1'b0, top};
    if (sum >= ROWS_S) begin
      sum = sum - ROWS_S;
    end
    return sum[ROW_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(ADDR_W'(prow) * COLUMNS_A) + ADDR_W'(col);
  endfunction

  // Latched item.
  action_t                act_q;
  logic [CHAR_W-1:0]      char_q;
  logic [READ_ROW_W-1:0]  rrow_q;
  logic [READ_COL_W-1:0]  rcol_q;

  // Console state.
  logic [COL_W-1:0]       cursor_col;
  logic [ROW_W-1:0]       cursor_row;
  logic [ROW_W-1:0]       top_row;
  logic [COLOR_W-1:0]     fg_color;
  logic [COLOR_W-1:0]     bg_color;

  // Fill sweep.
  logic [ADDR_W-1:0]      fill_addr;
  logic [ADDR_W-1:0]      fill_end;
  logic [CELL_W-1:0]      fill_word;

  // Screen memory.
  logic [CELL_W-1:0]      mem [CELLS];
  logic [CELL_W-1:0]      mem_rdata;
  logic                   read_hit;

  // Item decode.
  logic [COL_W-1:0]       col_next;
  logic [ROW_W-1:0]       row_next;
  logic [ROW_W-1:0]       top_next;
  logic                   put_wr;
  logic [ADDR_W-1:0]      put_addr;
  logic [CELL_W-1:0]      put_data;
  logic                   scroll;
  logic                   clear;
  logic                   rd_hit;
  logic [ADDR_W-1:0]      rd_addr;
  logic [COLOR_W*2-1:0]   attr;
  logic [ROW_W-1:0]       prow_cur;
  logic                   at_bottom;
  logic [ROW_W-1:0]       row_down;
  logic [ROW_W-1:0]       top_down;
  logic [COL_W-1:0]       back_col;
  logic [ADDR_W-1:0]      scroll_base;

  // Memory port and result.
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr;
  logic [CELL_W-1:0]      mem_wdata;
  logic [ROW_W-1:0]       pos_row;
  logic [COL_W-1:0]       pos_col;
  logic [POS_W-1:0]       pos_lin;

  // Helpers shared by several put cases.
  always_comb begin
    attr        = {bg_color, fg_color};
    prow_cur    = phys_row(cursor_row, top_row);
    at_bottom   = (cursor_row == LAST_ROW);
    row_down    = at_bottom ? cursor_row : cursor_row + 1'b1;
    top_down    = top_row;
    if (at_bottom) begin
      top_down = (top_row == LAST_ROW) ? '0 : top_row + 1'b1;
    end
    back_col    = (cursor_col == '0) ? '0 : cursor_col - 1'b1;
    scroll_base = cell_addr(top_row, '0);
    rd_addr     = cell_addr(phys_row(ROW_W'(rrow_q), top_row), COL_W'(rcol_q));
  end

  // Decode of the latched item into cursor moves and the single cell access.
  always_comb begin
    col_next = cursor_col;
    row_next = cursor_row;
    top_next = top_row;
    put_wr   = 1'b0;
    put_addr = cell_addr(prow_cur, cursor_col);
    put_data = {attr, char_q};
    scroll   = 1'b0;
    clear    = 1'b0;
    rd_hit   = 1'b0;
    case (act_q)
      ACT_PUT: begin
        if (char_q == CH_NEWLINE) begin
          col_next = '0;
          row_next = row_down;
          top_next = top_down;
          scroll   = at_bottom;
        end else if (char_q == CH_RETURN) begin
          col_next = '0;
        end else if (char_q == CH_BACKSPACE) begin
          col_next = back_col;
          put_wr   = 1'b1;
          put_addr = cell_addr(prow_cur, back_col);
          put_data = {attr, CH_SPACE};
        end else if (char_q >= CH_SPACE && char_q <= CH_PRINT_LAST) begin
          put_wr = 1'b1;
          if (cursor_col == LAST_COL) begin
            col_next = '0;
            row_next = row_down;
            top_next = top_down;
            scroll   = at_bottom;
          end else begin
            col_next = cursor_col + 1'b1;
          end
        end
      end
      ACT_CLEAR: begin
        clear    = 1'b1;
        col_next = '0;
        row_next = '0;
      end
      ACT_READ: begin
        rd_hit = ({1'b0, rrow_q} < ROWS_R) && ({1'b0, rcol_q} < COLUMNS_R);
      end
      default: begin
      end
    endcase
  end

  // Latch the accepted item.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_q  <= action_t'(action);
      char_q <= char_code;
      rrow_q <= read_row;
      rcol_q <= read_column;
    end
  end

  // Cursor, scroll offset and color registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
      top_row    <= '0;
      fg_color   <= RESET_FG;
      bg_color   <= RESET_BG;
    end else begin
      if (cmd.exec) begin
        cursor_col <= col_next;
        cursor_row <= row_next;
        top_row    <= top_next;
      end
      if (cfg_valid && cfg_index == CFG_FG_COLOR) begin
        fg_color <= cfg_data;
      end
      if (cfg_valid && cfg_index == CFG_BG_COLOR) begin
        bg_color <= cfg_data;
      end
    end
  end

  // Fill sweep: whole screen after reset and on clear, one row on scroll.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_addr <= '0;
      fill_end  <= LAST_CELL;
      fill_word <= RESET_CELL;
    end else if (cmd.exec && clear) begin
      fill_addr <= '0;
      fill_end  <= LAST_CELL;
      fill_word <= {attr, CH_SPACE};
    end else if (cmd.exec && scroll) begin
      fill_addr <= scroll_base;
      fill_end  <= scroll_base + ROW_SPAN;
      fill_word <= {attr, CH_SPACE};
    end else if (cmd.fill_step) begin
      fill_addr <= fill_addr + 1'b1;
    end
  end

  // One write port shared by the sweep and single-cell puts.
  always_comb begin
    mem_we    = cmd.fill_step || (cmd.exec && put_wr);
    mem_waddr = cmd.fill_step ? fill_addr : put_addr;
    mem_wdata = cmd.fill_step ? fill_word : put_data;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && rd_hit) begin
      mem_rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      read_hit <= rd_hit;
    end
  end

  // Cursor position of the result; a load in the execute cycle sees the new cursor.
  always_comb begin
    pos_row = cmd.exec ? row_next : cursor_row;
    pos_col = cmd.exec ? col_next : cursor_col;
    pos_lin = POS_W'(POS_W'(pos_row) * COLUMNS_P) + POS_W'(pos_col);
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      cursor_position <= pos_lin[CURSOR_W-1:0];
      cell_word       <= (!cmd.exec && read_hit) ? mem_rdata : '0;
    end
  end

  always_comb begin
    status.need_fill = scroll || clear;
    status.is_read   = (act_q == ACT_READ);
    status.fill_last = (fill_addr == fill_end);
    status.out_free  = !out_valid || out_ready;
  end

endmodule

>>> src/tcc_ctrl.sv
// Controller state machine of the text console: sequences accept, execute, fill and result.
module tcc_ctrl import tcc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_INIT: begin
        cmd.fill_step = 1'b1;
        if (status.fill_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (status.need_fill) begin
          state_next = ST_FILL;
        end else if (status.is_read) begin
          state_next = ST_DONE;
        end else if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (status.fill_last) begin
          if (status.out_free) begin
            cmd.load_out = 1'b1;
            state_next   = ST_IDLE;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the text console: directed table, random text sessions, color phases.
module tb_top import tcc_pkg::*; ();

  // One input item, with an optional result that is typed in by hand.
  typedef struct packed {
    action_t                act;
    logic [CHAR_W-1:0]      ch;
    logic [READ_ROW_W-1:0]  row;
    logic [READ_COL_W-1:0]  col;
    logic                   typed;
    logic [CURSOR_W-1:0]    exp_cursor;
    logic [CELL_W-1:0]      exp_cell;
  } console_item_t;

  // One result item as the block reports it.
  typedef struct packed {
    logic [CURSOR_W-1:0] cursor;
    logic [CELL_W-1:0]   word;
  } console_report_t;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_COIN,
    SINK_PATTERN,
    SINK_SPARSE
  } sink_mode_t;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES  = 2100;
  localparam int unsigned PHASES         = 6;
  localparam int unsigned PHASE_ITEMS    = 275;
  localparam int unsigned HOLD_AFTER     = 400;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned PRINT_LIMIT    = 40;

  // Color settings for the first phases; later phases pick their own.
  localparam logic [COLOR_W-1:0] PHASE_FG [4] = '{4'h0, 4'hF, 4'hF, 4'h0};
  localparam logic [COLOR_W-1:0] PHASE_BG [4] = '{4'h0, 4'hF, 4'h0, 4'hF};

  // Directed items; the typed results assume the reset colors.
  localparam int unsigned DIRECTED_N = 24;
  localparam console_item_t DIRECTED_TBL [DIRECTED_N] = '{
    '{ACT_READ,  8'h00,        5'd0,  7'd0,   1'b1, 11'd0,  RESET_CELL},
    '{ACT_READ,  8'h00,        5'd24, 7'd79,  1'b1, 11'd0,  RESET_CELL},
    '{ACT_READ,  8'h00,        5'd31, 7'd127, 1'b1, 11'd0,  16'h0000},
    '{ACT_READ,  8'h00,        5'd24, 7'd80,  1'b1, 11'd0,  16'h0000},
    '{ACT_READ,  8'h00,        5'd25, 7'd0,   1'b1, 11'd0,  16'h0000},
    '{ACT_NONE,  8'hFF,        5'd31, 7'd127, 1'b1, 11'd0,  16'h0000},
    '{ACT_PUT,   8'h41,        5'd0,  7'd0,   1'b1, 11'd1,  16'h0000},
    '{ACT_READ,  8'h00,        5'd0,  7'd0,   1'b1, 11'd1,  16'h0741},
    '{ACT_PUT,   CH_PRINT_LAST, 5'd0, 7'd0,   1'b1, 11'd2,  16'h0000},
    '{ACT_PUT,   CH_SPACE,     5'd0,  7'd0,   1'b1, 11'd3,  16'h0000},
    '{ACT_PUT,   8'h00,        5'd0,  7'd0,   1'b1, 11'd3,  16'h0000},
    '{ACT_PUT,   8'hFF,        5'd0,  7'd0,   1'b1, 11'd3,  16'h0000},
    '{ACT_PUT,   8'h80,        5'd0,  7'd0,   1'b1, 11'd3,  16'h0000},
    '{ACT_PUT,   8'h1F,        5'd0,  7'd0,   1'b1, 11'd3,  16'h0000},
    '{ACT_PUT,   CH_BACKSPACE, 5'd0,  7'd0,   1'b1, 11'd2,  16'h0000},
    '{ACT_READ,  8'h00,        5'd0,  7'd1,   1'b0, 11'd0,  16'h0000},
    '{ACT_PUT,   CH_RETURN,    5'd0,  7'd0,   1'b1, 11'd0,  16'h0000},
    '{ACT_PUT,   CH_BACKSPACE, 5'd0,  7'd0,   1'b1, 11'd0,  16'h0000},
    '{ACT_READ,  8'h00,        5'd0,  7'd0,   1'b1, 11'd0,  RESET_CELL},
    '{ACT_PUT,   CH_NEWLINE,   5'd0,  7'd0,   1'b1, 11'd80, 16'h0000},
    '{ACT_PUT,   8'h55,        5'd0,  7'd0,   1'b0, 11'd0,  16'h0000},
    '{ACT_CLEAR, 8'h00,        5'd0,  7'd0,   1'b1, 11'd0,  16'h0000},
    '{ACT_READ,  8'h00,        5'd0,  7'd1,   1'b1, 11'd0,  RESET_CELL},
    '{ACT_PUT,   8'h7E,        5'd0,  7'd0,   1'b0, 11'd0,  16'h0000}
  };

  logic clk;
  logic rst;

  tcc_in_if  in_ch ();
  tcc_out_if out_ch ();
  tcc_cfg_if cfg_ch ();

  text_console_cursor_scroll_top u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_ch)
  );

  // Shadow of the screen, cursor and colors.
  logic [CELL_W-1:0]  screen_img [CELLS];
  int unsigned        cur_row;
  int unsigned        cur_col;
  logic [COLOR_W-1:0] fg_now;
  logic [COLOR_W-1:0] bg_now;

  console_report_t due_reports [$];
  int unsigned     mismatch_count;
  int unsigned     reports_seen;
  int unsigned     effective_items;
  int unsigned     burst_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [CELL_W-1:0] blank_cell();
    return {bg_now, fg_now, CH_SPACE};
  endfunction

  // Move the cursor down one row, scrolling the screen at the bottom.
  function automatic void advance_row();
    cur_row++;
    if (cur_row >= ROWS) begin
      for (int i = 0; i < CELLS - COLUMNS; i++) screen_img[i] = screen_img[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_img[i] = blank_cell();
      cur_row = ROWS - 1;
    end
  endfunction

  // Apply one item to the shadow state and return the result it should give.
  function automatic console_report_t advance_console(console_item_t it);
    console_report_t rep;
    rep.word = '0;
    case (it.act)
      ACT_PUT: begin
        if (it.ch == CH_NEWLINE) begin
          cur_col = 0;
          advance_row();
        end else if (it.ch == CH_RETURN) begin
          cur_col = 0;
        end else if (it.ch == CH_BACKSPACE) begin
          if (cur_col > 0) cur_col--;
          screen_img[cur_row * COLUMNS + cur_col] = blank_cell();
        end else if (it.ch >= CH_SPACE && it.ch <= CH_PRINT_LAST) begin
          screen_img[cur_row * COLUMNS + cur_col] = {bg_now, fg_now, it.ch};
          cur_col++;
          if (cur_col >= COLUMNS) begin
            cur_col = 0;
            advance_row();
          end
        end
      end
      ACT_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_img[i] = blank_cell();
        cur_row = 0;
        cur_col = 0;
      end
      ACT_READ: begin
        if (it.row < ROWS && it.col < COLUMNS) rep.word = screen_img[it.row * COLUMNS + it.col];
      end
      default: ;
    endcase
    rep.cursor = CURSOR_W'(cur_row * COLUMNS + cur_col);
    return rep;
  endfunction

  function automatic console_item_t mk_item(action_t act, logic [CHAR_W-1:0] ch,
                                            logic [READ_ROW_W-1:0] row,
                                            logic [READ_COL_W-1:0] col);
    console_item_t it;
    it = '0;
    it.act = act;
    it.ch  = ch;
    it.row = row;
    it.col = col;
    return it;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("tb_top: mismatch: %s", msg);
  endtask

  // Offer one item in bursts with random gaps and log its result once taken.
  task automatic send_item(input console_item_t it);
    int unsigned     gap;
    console_report_t rep;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      case ($urandom_range(0, 9))
        0, 1, 2: gap = 0;
        9:       gap = $urandom_range(20, 60);
        default: gap = $urandom_range(1, 6);
      endcase
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.action      <= it.act;
    in_ch.char_code   <= it.ch;
    in_ch.read_row    <= it.row;
    in_ch.read_column <= it.col;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    rep = advance_console(it);
    if (it.typed) rep = {it.exp_cursor, it.exp_cell};
    due_reports.push_back(rep);
    if (it.act == ACT_CLEAR || it.act == ACT_READ ||
        (it.act == ACT_PUT && (it.ch == CH_NEWLINE || it.ch == CH_RETURN ||
         it.ch == CH_BACKSPACE || (it.ch >= CH_SPACE && it.ch <= CH_PRINT_LAST))))
      effective_items++;
  endtask

  // Write both color registers back to back.
  task automatic write_colors(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_FG_COLOR;
    cfg_ch.data  <= fg;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    fg_now = fg;
    cfg_ch.index <= CFG_BG_COLOR;
    cfg_ch.data  <= bg;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    bg_now = bg;
    cfg_ch.valid <= 1'b0;
  endtask

  // Wait for every pending result, then let any row fill finish.
  task automatic settle();
    while (due_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random console session: mostly text lines and line feeds, some edits, reads and noise.
  task automatic run_phase(input int unsigned quota);
    int unsigned       stop_at;
    int unsigned       kind;
    int unsigned       len;
    int unsigned       tail;
    action_t           act;
    logic [CHAR_W-1:0] ch;
    stop_at = effective_items + quota;
    while (effective_items < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        len = ($urandom_range(0, 4) == 0) ? COLUMNS : $urandom_range(0, 90);
        for (int i = 0; i < len; i++)
          send_item(mk_item(ACT_PUT, CHAR_W'($urandom_range(CH_SPACE, CH_PRINT_LAST)),
                            READ_ROW_W'($urandom), READ_COL_W'($urandom)));
        tail = $urandom_range(0, 9);
        if (tail < 7) send_item(mk_item(ACT_PUT, CH_NEWLINE, '0, '0));
        else if (tail < 9) send_item(mk_item(ACT_PUT, CH_RETURN, '0, '0));
      end else if (kind < 60) begin
        len = $urandom_range(1, 30);
        for (int i = 0; i < len; i++) send_item(mk_item(ACT_PUT, CH_NEWLINE, '0, '0));
      end else if (kind < 75) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 4) != 0)
            send_item(mk_item(ACT_READ, CHAR_W'($urandom),
                              READ_ROW_W'($urandom_range(0, ROWS - 1)),
                              READ_COL_W'($urandom_range(0, COLUMNS - 1))));
          else
            send_item(mk_item(ACT_READ, CHAR_W'($urandom), READ_ROW_W'($urandom),
                              READ_COL_W'($urandom)));
        end
      end else if (kind < 85) begin
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++) begin
          ch = ($urandom_range(0, 1) == 0) ? CH_BACKSPACE
                                          : CHAR_W'($urandom_range(CH_SPACE, CH_PRINT_LAST));
          send_item(mk_item(ACT_PUT, ch, '0, '0));
        end
      end else if (kind < 97) begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) begin
          act = action_t'($urandom_range(0, 3));
          // Clears are slow, so most of them in the noise turn into no-ops.
          if (act == ACT_CLEAR && $urandom_range(0, 7) != 0) act = ACT_NONE;
          send_item(mk_item(act, CHAR_W'($urandom), READ_ROW_W'($urandom),
                            READ_COL_W'($urandom)));
        end
      end else begin
        send_item(mk_item(ACT_CLEAR, CHAR_W'($urandom), READ_ROW_W'($urandom),
                          READ_COL_W'($urandom)));
      end
    end
  endtask

  // Stimulus and end of run.
  initial begin : stimulus
    rst               = 1'b1;
    in_ch.valid       = 1'b0;
    in_ch.action      = ACT_PUT;
    in_ch.char_code   = '0;
    in_ch.read_row    = '0;
    in_ch.read_column = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = CFG_FG_COLOR;
    cfg_ch.data       = '0;
    fg_now            = RESET_FG;
    bg_now            = RESET_BG;
    cur_row           = 0;
    cur_col           = 0;
    mismatch_count    = 0;
    effective_items   = 0;
    burst_left        = 0;
    for (int i = 0; i < CELLS; i++) screen_img[i] = RESET_CELL;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < DIRECTED_N; k++) send_item(DIRECTED_TBL[k]);
    in_ch.valid <= 1'b0;

    for (int k = 0; k < PHASES; k++) begin
      settle();
      if (k < 4) write_colors(PHASE_FG[k], PHASE_BG[k]);
      else write_colors(COLOR_W'($urandom), COLOR_W'($urandom));
      run_phase(PHASE_ITEMS);
      in_ch.valid <= 1'b0;
    end

    settle();
    if (mismatch_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Result side: stalls on its own pattern and holds off once for a long stretch.
  initial begin : result_sink
    int unsigned       mode_left;
    int unsigned       hold_left;
    bit                held_once;
    sink_mode_t        mode;
    logic [7:0]        pat;
    logic              rdy;
    console_report_t   want;
    out_ch.ready = 1'b0;
    reports_seen = 0;
    mode_left    = 0;
    hold_left    = 0;
    held_once    = 1'b0;
    mode         = SINK_OPEN;
    pat          = '1;
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        reports_seen++;
        if (due_reports.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: cursor %0d cell %h",
                                    out_ch.cursor_position, out_ch.cell_word));
        end else begin
          want = due_reports.pop_front();
          if (out_ch.cursor_position !== want.cursor)
            report_mismatch($sformatf("result %0d cursor_position %0d, expected %0d",
                                      reports_seen, out_ch.cursor_position, want.cursor));
          if (out_ch.cell_word !== want.word)
            report_mismatch($sformatf("result %0d cell_word %h, expected %h",
                                      reports_seen, out_ch.cell_word, want.word));
        end
      end

      // Choose the next ready value.
      if (!held_once && reports_seen >= HOLD_AFTER) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = sink_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 120);
        pat       = 8'($urandom);
      end
      mode_left--;
      case (mode)
        SINK_OPEN:    rdy = 1'b1;
        SINK_COIN:    rdy = 1'($urandom_range(0, 1));
        SINK_PATTERN: begin
          rdy = pat[0];
          pat = {pat[0], pat[7:1]};
        end
        default:      rdy = ($urandom_range(0, 3) == 0);
      endcase
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end
      out_ch.ready <= rdy;
    end
  end

  // Watchdog on cycles in which no channel moves an item.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
          (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("tb_top: timeout after %0d quiet cycles", quiet_cycles);
          $display("tb_top: errors");
          $finish;
        end
      end
    end
  end

endmodule

>>> filelist.f
src/tcc_pkg.sv
src/tcc_if.sv
src/tcc_datapath.sv
src/tcc_ctrl.sv
src/text_console_cursor_scroll_top.sv
verif/tb_top.sv
